@@ hdl/qvr_pkg.sv @@
// Package with widths, register indexes and term tables of the quaternion vector rotator.
package qvr_pkg;

    localparam int WORD_W   = 32;
    localparam int CFG_IW   = 3;
    localparam int NUM_REG  = 4;
    localparam int NUM_VEC  = 3;
    localparam int NUM_TERM = 4;
    localparam int PROD_W   = 2 * WORD_W;
    localparam int T_W      = PROD_W + 2;
    localparam int SPLIT    = 33;
    localparam int LO_W     = SPLIT + 1;
    localparam int HI_W     = T_W - SPLIT;
    localparam int LOP_W    = LO_W + WORD_W;
    localparam int HIP_W    = HI_W + WORD_W;
    localparam int LOS_W    = LOP_W + 2;
    localparam int HIS_W    = HIP_W + 2;
    localparam int FULL_W   = 101;
    localparam int RND_LSB  = 60;
    localparam int SAT_MSB  = RND_LSB + WORD_W - 1;
    localparam int STAGES   = 6;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [T_W-1:0]    t_tval;
    typedef logic signed [LOP_W-1:0]  t_lo_prod;
    typedef logic signed [HIP_W-1:0]  t_hi_prod;
    typedef logic signed [LOS_W-1:0]  t_lo_sum;
    typedef logic signed [HIS_W-1:0]  t_hi_sum;
    typedef logic signed [FULL_W-1:0] t_full;

    typedef enum logic [CFG_IW-1:0] {
        REG_ROT_X = 3'd0,
        REG_ROT_Y = 3'd1,
        REG_ROT_Z = 3'd2,
        REG_ROT_W = 3'd3
    } t_reg_idx;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;
    localparam logic [1:0] AX_W = 2'd3;

    localparam t_word ROT_W_RESET = 32'sh4000_0000;

    localparam t_full ROUND_BIAS = t_full'(1) <<< (RND_LSB - 1);

    // Second product: component c sums t[TERM_T] * q[TERM_Q], negated where TERM_NEG.
    localparam logic [1:0] TERM_T [0:NUM_VEC-1][0:NUM_TERM-1] = '{
        '{AX_X, AX_W, AX_Y, AX_Z},
        '{AX_Y, AX_W, AX_Z, AX_X},
        '{AX_Z, AX_W, AX_X, AX_Y}
    };
    localparam logic [1:0] TERM_Q [0:NUM_VEC-1][0:NUM_TERM-1] = '{
        '{AX_W, AX_X, AX_Z, AX_Y},
        '{AX_W, AX_Y, AX_X, AX_Z},
        '{AX_W, AX_Z, AX_Y, AX_X}
    };
    localparam logic TERM_NEG [0:NUM_TERM-1] = '{1'b0, 1'b1, 1'b1, 1'b0};

endpackage

@@ hdl/qvr_in_if.sv @@
// Input channel interface carrying one vector word.
interface qvr_in_if;
    logic                       valid;
    logic                       ready;
    logic signed [qvr_pkg::WORD_W-1:0] in_x;
    logic signed [qvr_pkg::WORD_W-1:0] in_y;
    logic signed [qvr_pkg::WORD_W-1:0] in_z;

    modport source (output valid, output in_x, output in_y, output in_z, input ready);
    modport sink   (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

@@ hdl/qvr_out_if.sv @@
// Output channel interface carrying one rotated vector word.
interface qvr_out_if;
    logic                       valid;
    logic                       ready;
    logic signed [qvr_pkg::WORD_W-1:0] out_x;
    logic signed [qvr_pkg::WORD_W-1:0] out_y;
    logic signed [qvr_pkg::WORD_W-1:0] out_z;
    logic                       clipped;

    modport source (output valid, output out_x, output out_y, output out_z,
                    output clipped, input ready);
    modport sink   (input valid, input out_x, input out_y, input out_z,
                    input clipped, output ready);
endinterface

@@ hdl/quaternion_vector_rotate_core.sv @@
// Top level of the quaternion vector rotator: six-stage pipeline computing q * v * conj(q).
//
//  channel   direction  payload                          handshake
//  i_vec     in         in_x, in_y, in_z (Q16.16)        valid / ready
//  o_vec     out        out_x, out_y, out_z, clipped     valid / ready
//  i_cfg_*   in         index, 32-bit quaternion data    write enable
//
// One word enters per cycle while no stall holds the input, and passes through the six
// multiply, add and saturate stages. Reset clears all stage valid bits and loads the
// identity quaternion. A stall ripples back only through full stages, so bubbles are
// squeezed out and no word is lost or repeated.
module quaternion_vector_rotate_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [qvr_pkg::CFG_IW-1:0]        i_cfg_idx,
    input  logic [qvr_pkg::WORD_W-1:0]        i_cfg_data,
    qvr_in_if.sink                            i_vec,
    qvr_out_if.source                         o_vec
);

    qvr_pkg::t_word    r_rot   [0:qvr_pkg::NUM_REG-1];
    logic [qvr_pkg::STAGES-1:0] r_vld;
    logic [qvr_pkg::STAGES-1:0] en;

    qvr_pkg::t_word    vin     [0:qvr_pkg::NUM_VEC-1];
    qvr_pkg::t_prod    r1_p    [0:qvr_pkg::NUM_REG-1][0:qvr_pkg::NUM_VEC-1];
    qvr_pkg::t_tval    r2_t    [0:qvr_pkg::NUM_REG-1];
    qvr_pkg::t_tval    n2_t    [0:qvr_pkg::NUM_REG-1];
    qvr_pkg::t_lo_prod r3_lo   [0:qvr_pkg::NUM_VEC-1][0:qvr_pkg::NUM_TERM-1];
    qvr_pkg::t_hi_prod r3_hi   [0:qvr_pkg::NUM_VEC-1][0:qvr_pkg::NUM_TERM-1];
    qvr_pkg::t_lo_sum  r4_lo   [0:qvr_pkg::NUM_VEC-1];
    qvr_pkg::t_hi_sum  r4_hi   [0:qvr_pkg::NUM_VEC-1];
    qvr_pkg::t_lo_sum  n4_lo   [0:qvr_pkg::NUM_VEC-1];
    qvr_pkg::t_hi_sum  n4_hi   [0:qvr_pkg::NUM_VEC-1];
    qvr_pkg::t_full    r5_f    [0:qvr_pkg::NUM_VEC-1];
    qvr_pkg::t_word    r6_o    [0:qvr_pkg::NUM_VEC-1];
    qvr_pkg::t_word    n6_o    [0:qvr_pkg::NUM_VEC-1];
    logic              r6_clip;
    logic              n6_clip;

    assign vin[0] = i_vec.in_x;
    assign vin[1] = i_vec.in_y;
    assign vin[2] = i_vec.in_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0] <= '0;
            r_rot[1] <= '0;
            r_rot[2] <= '0;
            r_rot[3] <= qvr_pkg::ROT_W_RESET;
        end else if (i_cfg_we) begin
            case (qvr_pkg::t_reg_idx'(i_cfg_idx))
                qvr_pkg::REG_ROT_X: r_rot[0] <= i_cfg_data;
                qvr_pkg::REG_ROT_Y: r_rot[1] <= i_cfg_data;
                qvr_pkg::REG_ROT_Z: r_rot[2] <= i_cfg_data;
                qvr_pkg::REG_ROT_W: r_rot[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        en[qvr_pkg::STAGES-1] = !r_vld[qvr_pkg::STAGES-1] || o_vec.ready;
        for (int k = qvr_pkg::STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_vec.ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_vec.valid;
            end
            for (int k = 1; k < qvr_pkg::STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 2 forms t = q * v.
    always_comb begin
        n2_t[qvr_pkg::AX_X] = qvr_pkg::t_tval'(r1_p[qvr_pkg::AX_W][qvr_pkg::AX_X])
                            + qvr_pkg::t_tval'(r1_p[qvr_pkg::AX_Y][qvr_pkg::AX_Z])
                            - qvr_pkg::t_tval'(r1_p[qvr_pkg::AX_Z][qvr_pkg::AX_Y]);
        n2_t[qvr_pkg::AX_Y] = qvr_pkg::t_tval'(r1_p[qvr_pkg::AX_W][qvr_pkg::AX_Y])
                            + qvr_pkg::t_tval'(r1_p[qvr_pkg::AX_Z][qvr_pkg::AX_X])
                            - qvr_pkg::t_tval'(r1_p[qvr_pkg::AX_X][qvr_pkg::AX_Z]);
        n2_t[qvr_pkg::AX_Z] = qvr_pkg::t_tval'(r1_p[qvr_pkg::AX_W][qvr_pkg::AX_Z])
                            + qvr_pkg::t_tval'(r1_p[qvr_pkg::AX_X][qvr_pkg::AX_Y])
                            - qvr_pkg::t_tval'(r1_p[qvr_pkg::AX_Y][qvr_pkg::AX_X]);
        n2_t[qvr_pkg::AX_W] = -(qvr_pkg::t_tval'(r1_p[qvr_pkg::AX_X][qvr_pkg::AX_X])
                            + qvr_pkg::t_tval'(r1_p[qvr_pkg::AX_Y][qvr_pkg::AX_Y])
                            + qvr_pkg::t_tval'(r1_p[qvr_pkg::AX_Z][qvr_pkg::AX_Z]));
    end

    // Stage 4 sums the signed low and high partial products of each component.
    always_comb begin
        for (int c = 0; c < qvr_pkg::NUM_VEC; c++) begin
            n4_lo[c] = '0;
            n4_hi[c] = '0;
            for (int k = 0; k < qvr_pkg::NUM_TERM; k++) begin
                if (qvr_pkg::TERM_NEG[k]) begin
                    n4_lo[c] = n4_lo[c] - qvr_pkg::t_lo_sum'(r3_lo[c][k]);
                    n4_hi[c] = n4_hi[c] - qvr_pkg::t_hi_sum'(r3_hi[c][k]);
                end else begin
                    n4_lo[c] = n4_lo[c] + qvr_pkg::t_lo_sum'(r3_lo[c][k]);
                    n4_hi[c] = n4_hi[c] + qvr_pkg::t_hi_sum'(r3_hi[c][k]);
                end
            end
        end
    end

    // Stage 6 saturates the rounded value to Q16.16.
    always_comb begin
        n6_clip = 1'b0;
        for (int c = 0; c < qvr_pkg::NUM_VEC; c++) begin
            if (r5_f[c][qvr_pkg::FULL_W-1:qvr_pkg::SAT_MSB]
                    == {(qvr_pkg::FULL_W - qvr_pkg::SAT_MSB){r5_f[c][qvr_pkg::SAT_MSB]}}) begin
                n6_o[c] = r5_f[c][qvr_pkg::SAT_MSB:qvr_pkg::RND_LSB];
            end else begin
                n6_clip = 1'b1;
                n6_o[c] = r5_f[c][qvr_pkg::FULL_W-1]
                        ? {1'b1, {(qvr_pkg::WORD_W-1){1'b0}}}
                        : {1'b0, {(qvr_pkg::WORD_W-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            for (int i = 0; i < qvr_pkg::NUM_REG; i++) begin
                for (int j = 0; j < qvr_pkg::NUM_VEC; j++) begin
                    r1_p[i][j] <= r_rot[i] * vin[j];
                end
            end
        end
        if (en[1]) begin
            r2_t <= n2_t;
        end
        if (en[2]) begin
            for (int c = 0; c < qvr_pkg::NUM_VEC; c++) begin
                for (int k = 0; k < qvr_pkg::NUM_TERM; k++) begin
                    r3_lo[c][k] <= $signed({1'b0,
                                   r2_t[qvr_pkg::TERM_T[c][k]][qvr_pkg::SPLIT-1:0]})
                                 * r_rot[qvr_pkg::TERM_Q[c][k]];
                    r3_hi[c][k] <= $signed(r2_t[qvr_pkg::TERM_T[c][k]]
                                   [qvr_pkg::T_W-1:qvr_pkg::SPLIT])
                                 * r_rot[qvr_pkg::TERM_Q[c][k]];
                end
            end
        end
        if (en[3]) begin
            r4_lo <= n4_lo;
            r4_hi <= n4_hi;
        end
        if (en[4]) begin
            for (int c = 0; c < qvr_pkg::NUM_VEC; c++) begin
                r5_f[c] <= (qvr_pkg::t_full'(r4_hi[c]) <<< qvr_pkg::SPLIT)
                         + qvr_pkg::t_full'(r4_lo[c]) + qvr_pkg::ROUND_BIAS;
            end
        end
        if (en[5]) begin
            r6_o    <= n6_o;
            r6_clip <= n6_clip;
        end
    end

    assign o_vec.valid   = r_vld[qvr_pkg::STAGES-1];
    assign o_vec.out_x   = r6_o[0];
    assign o_vec.out_y   = r6_o[1];
    assign o_vec.out_z   = r6_o[2];
    assign o_vec.clipped = r6_clip;

endmodule

@@ tb/sv/quaternion_vector_rotate_core_tb.sv @@
// Self-checking testbench for the quaternion vector rotator: directed table plus random phases.
`timescale 1ns / 1ps

module quaternion_vector_rotate_core_tb;
    import qvr_pkg::*;

    localparam int CYCLE_LIMIT     = 500_000;
    localparam int HOLD_CYCLES     = 300;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 152;
    localparam int DIR_N           = 18;

    localparam t_word Q_ONE  = ROT_W_RESET;
    localparam t_word Q_HALF = 32'sh2000_0000;
    localparam t_word Q_S45  = 32'sh2D41_3CCD;
    localparam t_word W_MAX  = 32'sh7FFF_FFFF;
    localparam t_word W_MIN  = 32'sh8000_0000;

    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
        logic  clip;
    } rotated_t;

    typedef struct packed {
        t_word    qx;
        t_word    qy;
        t_word    qz;
        t_word    qw;
        t_word    vx;
        t_word    vy;
        t_word    vz;
        logic     junk;
        logic     golden;
        rotated_t gold;
    } vec_case_t;

    typedef enum int {Q_UNITISH, Q_FULL, Q_EXTREME, Q_AXIS} quat_mode_t;

    // Rows with golden set carry a result that follows directly from the quaternion.
    localparam vec_case_t DIR_CASES [DIR_N] = '{
        '{0, 0, 0, Q_ONE, 0, 0, 0, 1'b0, 1'b1, '{0, 0, 0, 1'b0}},
        '{0, 0, 0, Q_ONE, W_MAX, W_MIN, 1, 1'b0, 1'b1, '{W_MAX, W_MIN, 1, 1'b0}},
        '{0, 0, 0, Q_ONE, -32'sd1, 32'sh0001_0000, 32'shFFFF_0000, 1'b1, 1'b1,
          '{-32'sd1, 32'sh0001_0000, 32'shFFFF_0000, 1'b0}},
        '{0, 0, 0, W_MIN, W_MAX, W_MIN, 0, 1'b0, 1'b1, '{W_MAX, W_MIN, 0, 1'b1}},
        '{0, 0, 0, W_MIN, 32'sh1FFF_FFFF, 32'shE000_0000, 5, 1'b0, 1'b1,
          '{32'sh7FFF_FFFC, W_MIN, 32'sd20, 1'b0}},
        '{0, 0, 0, 0, W_MAX, W_MAX, W_MAX, 1'b0, 1'b1, '{0, 0, 0, 1'b0}},
        '{0, 0, Q_ONE, 0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b0, 1'b1,
          '{32'shFFFF_0000, 32'shFFFE_0000, 32'sh0003_0000, 1'b0}},
        '{0, 0, Q_ONE, 0, W_MIN, 7, W_MIN, 1'b0, 1'b1, '{W_MAX, -32'sd7, W_MIN, 1'b1}},
        '{Q_ONE, 0, 0, 0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b0, 1'b1,
          '{32'sh0001_0000, 32'shFFFE_0000, 32'shFFFD_0000, 1'b0}},
        '{0, Q_ONE, 0, 0, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 1'b0, 1'b1,
          '{32'shFFFF_0000, 32'sh0002_0000, 32'shFFFD_0000, 1'b0}},
        '{0, 0, 0, Q_HALF, 2, -32'sd2, -32'sd6, 1'b0, 1'b1, '{1, 0, -32'sd1, 1'b0}},
        '{0, 0, Q_S45, Q_S45, 32'sh0001_0000, 0, 0, 1'b0, 1'b0, '{0, 0, 0, 1'b0}},
        '{Q_S45, 0, 0, Q_S45, 32'sh0123_4567, 32'shFEDC_BA98, 32'sh0000_8000, 1'b0, 1'b0,
          '{0, 0, 0, 1'b0}},
        '{W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MIN, W_MAX, 1'b0, 1'b0, '{0, 0, 0, 1'b0}},
        '{W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 1'b0, 1'b0, '{0, 0, 0, 1'b0}},
        '{W_MIN, W_MAX, W_MIN, W_MAX, 32'sh1234_5678, 32'sh9ABC_DEF0, 32'sh0F0F_0F0F,
          1'b0, 1'b0, '{0, 0, 0, 1'b0}},
        '{32'sh1234_5678, 32'shEDCB_A988, 32'sh0BAD_F00D, 32'sh3C6E_F372, 1, -32'sd1, 0,
          1'b0, 1'b0, '{0, 0, 0, 1'b0}},
        '{0, 0, 0, Q_ONE, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333, 1'b0, 1'b1,
          '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh3333_3333, 1'b0}}
    };

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_IW-1:0]   cfg_idx;
    logic [WORD_W-1:0]   cfg_data;

    qvr_in_if  vec_in ();
    qvr_out_if vec_out ();

    quaternion_vector_rotate_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_vec      (vec_in),
        .o_vec      (vec_out)
    );

    t_word    quat_x, quat_y, quat_z, quat_w;
    rotated_t rotated_q [$];
    int       n_errors   = 0;
    int       n_sent     = 0;
    int       n_rotated  = 0;
    int       n_clipped  = 0;
    int       n_settings = 0;
    int       cycles     = 0;
    bit       gaps_on    = 1'b1;
    bit       rx_random  = 1'b1;
    bit       hold_go    = 1'b0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [WORD_W:0] round_q16(input logic signed [127:0] acc);
        logic signed [127:0] r;
        r = (acc + (128'sd1 <<< 59)) >>> 60;
        if (r > (128'sd1 <<< 31) - 128'sd1) begin
            return {1'b1, W_MAX};
        end else if (r < -(128'sd1 <<< 31)) begin
            return {1'b1, W_MIN};
        end
        return {1'b0, r[WORD_W-1:0]};
    endfunction

    // Computes q * v * conj(q) exactly, then rounds and saturates each component to Q16.16.
    function automatic rotated_t rotate_vec(input t_word x, input t_word y, input t_word z);
        logic signed [127:0] vx, vy, vz, qx, qy, qz, qw;
        logic signed [127:0] tx, ty, tz, tw;
        logic [WORD_W:0]     rx, ry, rz;
        rotated_t            res;
        vx = x;
        vy = y;
        vz = z;
        qx = quat_x;
        qy = quat_y;
        qz = quat_z;
        qw = quat_w;
        tx = qw * vx + qy * vz - qz * vy;
        ty = qw * vy + qz * vx - qx * vz;
        tz = qw * vz + qx * vy - qy * vx;
        tw = -(qx * vx + qy * vy + qz * vz);
        rx = round_q16(tx * qw - tw * qx - ty * qz + tz * qy);
        ry = round_q16(ty * qw - tw * qy - tz * qx + tx * qz);
        rz = round_q16(tz * qw - tw * qz - tx * qy + ty * qx);
        res.x    = rx[WORD_W-1:0];
        res.y    = ry[WORD_W-1:0];
        res.z    = rz[WORD_W-1:0];
        res.clip = rx[WORD_W] | ry[WORD_W] | rz[WORD_W];
        return res;
    endfunction

    function automatic t_word rand_quat_comp(input quat_mode_t mode);
        case (mode)
            Q_UNITISH: return t_word'($urandom_range(0, 32'h4000_0000)) - Q_HALF;
            Q_FULL:    return t_word'($urandom);
            Q_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return W_MIN;
                    1: return W_MAX;
                    2: return 0;
                    3: return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            default: begin
                if ($urandom_range(0, 3) == 0) begin
                    return ($urandom_range(0, 1) == 1) ? Q_ONE : -Q_ONE;
                end
                return t_word'($urandom_range(0, 32'h2000)) - 32'sh1000;
            end
        endcase
    endfunction

    function automatic t_word rand_vec_comp();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            return t_word'($urandom);
        end else if (pick < 75) begin
            return t_word'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
        end else if (pick < 90) begin
            return t_word'($urandom_range(0, 32'h2000_0000)) - 32'sh1000_0000;
        end
        case ($urandom_range(0, 4))
            0: return W_MIN;
            1: return W_MAX;
            2: return 0;
            3: return 1;
            default: return -32'sd1;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input t_word data);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            REG_ROT_X: quat_x = data;
            REG_ROT_Y: quat_y = data;
            REG_ROT_Z: quat_z = data;
            REG_ROT_W: quat_w = data;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        @(negedge clk);
        vec_in.valid <= 1'b0;
        while (rotated_q.size() != 0) @(posedge clk);
        repeat (STAGES + 2) @(posedge clk);
    endtask

    // Loads a new quaternion once the pipeline is empty; junk also hits the unused indexes.
    task automatic set_quat(input t_word qx, input t_word qy, input t_word qz, input t_word qw,
                            input bit junk);
        wait_drained();
        write_reg(REG_ROT_X, qx);
        write_reg(REG_ROT_Y, qy);
        write_reg(REG_ROT_Z, qz);
        write_reg(REG_ROT_W, qw);
        if (junk) begin
            for (int k = NUM_REG; k < 2 ** CFG_IW; k++) begin
                write_reg(CFG_IW'(k), t_word'($urandom));
            end
        end
        @(negedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic send_vec(input t_word x, input t_word y, input t_word z,
                            input rotated_t want);
        int gap;
        int pick;
        gap  = 0;
        pick = $urandom_range(0, 99);
        if (gaps_on && pick >= 70) begin
            gap = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(10, 50);
        end
        repeat (gap) begin
            @(negedge clk);
            vec_in.valid <= 1'b0;
        end
        @(negedge clk);
        vec_in.valid <= 1'b1;
        vec_in.in_x  <= x;
        vec_in.in_y  <= y;
        vec_in.in_z  <= z;
        @(posedge clk);
        while (!vec_in.ready) @(posedge clk);
        rotated_q.push_back(want);
        n_sent++;
    endtask

    initial begin : rx_proc
        int   hold_left;
        int   stall_left;
        int   pick;
        logic rdy;
        hold_left     = 0;
        stall_left    = 0;
        vec_out.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_go) begin
                hold_go   = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!rx_random) begin
                rdy = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else begin
                pick = $urandom_range(0, 99);
                rdy  = (pick < 75);
                if (pick >= 75) begin
                    stall_left = (pick < 96) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
            vec_out.ready <= rdy;
        end
    end

    initial begin : out_check
        rotated_t want;
        forever begin
            @(posedge clk);
            if (rst_n && vec_out.valid && vec_out.ready) begin
                n_rotated++;
                if (vec_out.clipped) n_clipped++;
                if (rotated_q.size() == 0) begin
                    $error("unexpected word: out_x %h out_y %h out_z %h clipped %b",
                           vec_out.out_x, vec_out.out_y, vec_out.out_z, vec_out.clipped);
                    n_errors++;
                end else begin
                    want = rotated_q.pop_front();
                    if (vec_out.out_x !== want.x) begin
                        $error("out_x: expected %h, got %h", want.x, vec_out.out_x);
                        n_errors++;
                    end
                    if (vec_out.out_y !== want.y) begin
                        $error("out_y: expected %h, got %h", want.y, vec_out.out_y);
                        n_errors++;
                    end
                    if (vec_out.out_z !== want.z) begin
                        $error("out_z: expected %h, got %h", want.z, vec_out.out_z);
                        n_errors++;
                    end
                    if (vec_out.clipped !== want.clip) begin
                        $error("clipped: expected %b, got %b", want.clip, vec_out.clipped);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin : stimulus
        vec_case_t  row;
        quat_mode_t qmode;
        t_word      q [4];
        t_word      x, y, z;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_data     = '0;
        vec_in.valid = 1'b0;
        vec_in.in_x  = '0;
        vec_in.in_y  = '0;
        vec_in.in_z  = '0;
        quat_x       = 0;
        quat_y       = 0;
        quat_z       = 0;
        quat_w       = ROT_W_RESET;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            row = DIR_CASES[i];
            if (row.junk || row.qx != quat_x || row.qy != quat_y
                    || row.qz != quat_z || row.qw != quat_w) begin
                set_quat(row.qx, row.qy, row.qz, row.qw, row.junk);
            end
            send_vec(row.vx, row.vy, row.vz,
                     row.golden ? row.gold : rotate_vec(row.vx, row.vy, row.vz));
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            qmode = quat_mode_t'(ph % 4);
            foreach (q[c]) q[c] = rand_quat_comp(qmode);
            set_quat(q[0], q[1], q[2], q[3], ph == 7);
            gaps_on   = (ph % 3 != 1);
            rx_random = (ph % 3 != 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 2 && n == 40) hold_go = 1'b1;
                if (ph == 5 && n == 70) wait_drained();
                x = rand_vec_comp();
                y = rand_vec_comp();
                z = rand_vec_comp();
                send_vec(x, y, z, rotate_vec(x, y, z));
            end
        end

        wait_drained();
        repeat (4 * STAGES) @(posedge clk);
        $display("Sent %0d vectors under %0d quaternion settings; %0d results checked.",
                 n_sent, n_settings, n_rotated);
        $display("%0d results saturated, %0d mismatches.", n_clipped, n_errors);
        if (n_errors == 0 && rotated_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
